// ===== hw/rtl/orad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orad_pkg: shared types and constants of the out-of-range alarm detector
// Holds the register indexes, item and result layouts, the detector state
// encoding and the small helper functions used by the detector modules.
// ----------------------------------------------------------------------------
package orad_pkg;

  localparam int unsigned NUM_COND    = 4;
  localparam int unsigned CHAIN_STEPS = 4;

  localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

  // Configuration register indexes.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HIGH_LIMIT     = 3'd0;
  localparam cfg_idx_t CFG_LOW_LIMIT      = 3'd1;
  localparam cfg_idx_t CFG_DEADBAND       = 3'd2;
  localparam cfg_idx_t CFG_TIME_DELAY     = 3'd3;
  localparam cfg_idx_t CFG_ESCALATE_AFTER = 3'd4;

  // Item kinds.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;
  localparam logic [1:0] KIND_MAINT  = 2'd3;

  // Condition positions in the condition vectors.
  localparam int unsigned C_HI  = 0;
  localparam int unsigned C_LO  = 1;
  localparam int unsigned C_RHI = 2;
  localparam int unsigned C_RLO = 3;

  // Note event codes.
  localparam logic [2:0] EV_NORMAL  = 3'd0;
  localparam logic [2:0] EV_HIGH    = 3'd1;
  localparam logic [2:0] EV_LOW     = 3'd2;
  localparam logic [2:0] EV_FAULT   = 3'd3;
  localparam logic [2:0] EV_OVERDUE = 3'd4;

  // Reported state codes.
  localparam logic [1:0] CODE_NORMAL = 2'd0;
  localparam logic [1:0] CODE_HIGH   = 2'd1;
  localparam logic [1:0] CODE_LOW    = 2'd2;
  localparam logic [1:0] CODE_FAULT  = 2'd3;

  typedef enum logic [3:0] {
    ST_NORMAL = 4'b0001,
    ST_HIGH   = 4'b0010,
    ST_LOW    = 4'b0100,
    ST_FAULT  = 4'b1000
  } det_state_t;

  typedef struct packed {
    logic signed [31:0] upper_lim;
    logic signed [31:0] lower_lim;
    logic        [30:0] deadband;
    logic        [31:0] time_delay;
    logic        [31:0] escalate_after;
  } orad_cfg_t;

  typedef struct packed {
    logic        [1:0]  kind;
    logic        [31:0] now;
    logic signed [31:0] sample_value;
    logic               bad_reading;
    logic               maintenance_on;
  } orad_item_t;

  typedef struct packed {
    logic               note_valid;
    logic        [2:0]  note_event;
    logic        [31:0] note_time;
    logic signed [31:0] note_value;
    logic        [1:0]  detector_state;
  } orad_result_t;

  // Elapsed time, taken as zero when the clock appears to run backwards.
  function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] start);
    return (now >= start) ? (now - start) : 32'd0;
  endfunction

  function automatic logic [1:0] state_code(input det_state_t s);
    logic [1:0] code;
    case (s)
      ST_NORMAL: code = CODE_NORMAL;
      ST_HIGH:   code = CODE_HIGH;
      ST_LOW:    code = CODE_LOW;
      ST_FAULT:  code = CODE_FAULT;
      default:   code = CODE_NORMAL;
    endcase
    return code;
  endfunction

  // One step of the detector transition rules.
  function automatic det_state_t next_state(input det_state_t s, input logic fault,
                                            input logic [NUM_COND-1:0] held);
    det_state_t nx;
    nx = s;
    if (fault) begin
      nx = ST_FAULT;
    end else begin
      case (s)
        ST_FAULT: nx = ST_NORMAL;
        ST_NORMAL: begin
          if (held[C_HI]) nx = ST_HIGH;
          else if (held[C_LO]) nx = ST_LOW;
        end
        ST_HIGH: begin
          if (held[C_LO]) nx = ST_LOW;
          else if (held[C_RHI]) nx = ST_NORMAL;
        end
        ST_LOW: begin
          if (held[C_HI]) nx = ST_HIGH;
          else if (held[C_RLO]) nx = ST_NORMAL;
        end
        default: nx = ST_NORMAL;
      endcase
    end
    return nx;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/orad_cond.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orad_cond: condition evaluation
// Compares a sample against the limits and deadband, updates the four
// condition runs and reports which conditions have held for the delay.
// ----------------------------------------------------------------------------
module orad_cond (
  input  orad_pkg::orad_item_t                   item,
  input  orad_pkg::orad_cfg_t                    cfg,
  input  logic [orad_pkg::NUM_COND-1:0]          active_cur,
  input  logic [orad_pkg::NUM_COND-1:0][31:0]    start_cur,
  output logic [orad_pkg::NUM_COND-1:0]          active_nxt,
  output logic [orad_pkg::NUM_COND-1:0][31:0]    start_nxt,
  output logic [orad_pkg::NUM_COND-1:0]          held
);
  import orad_pkg::*;

  logic signed [33:0]    v34;
  logic signed [33:0]    hi34;
  logic signed [33:0]    lo34;
  logic signed [33:0]    db34;
  logic signed [33:0]    hi_ret;
  logic signed [33:0]    lo_ret;
  logic [NUM_COND-1:0]   cond;

  // Limits plus or minus the deadband are formed at 34 bits so they never wrap.
  assign v34    = 34'(item.sample_value);
  assign hi34   = 34'(cfg.upper_lim);
  assign lo34   = 34'(cfg.lower_lim);
  assign db34   = $signed({3'b000, cfg.deadband});
  assign hi_ret = hi34 - db34;
  assign lo_ret = lo34 + db34;

  always_comb begin
    cond        = '0;
    cond[C_HI]  = v34 > hi34;
    cond[C_LO]  = v34 < lo34;
    cond[C_RHI] = v34 < hi_ret;
    cond[C_RLO] = v34 > lo_ret;
  end

  always_comb begin
    active_nxt = active_cur;
    start_nxt  = start_cur;
    if (item.kind == KIND_SAMPLE) begin
      if (item.bad_reading) begin
        active_nxt = '0;
      end else begin
        for (int i = 0; i < NUM_COND; i++) begin
          active_nxt[i] = cond[i];
          if (cond[i] && !active_cur[i]) start_nxt[i] = item.now;
        end
      end
    end
    for (int i = 0; i < NUM_COND; i++) begin
      held[i] = active_nxt[i] && (since(item.now, start_nxt[i]) >= cfg.time_delay);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/orad_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// orad_core: detector state and notification
// Holds the detector state, runs the transition chain and the acknowledge,
// maintenance and escalation bookkeeping for one item per cycle while step is high.
// ----------------------------------------------------------------------------
module orad_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  orad_pkg::orad_item_t  item,
  input  orad_pkg::orad_cfg_t   cfg,
  output orad_pkg::orad_result_t result
);
  import orad_pkg::*;

  logic signed [31:0]           latest_r, latest_nxt;
  logic [NUM_COND-1:0]          active_r, active_nxt;
  logic [NUM_COND-1:0][31:0]    start_r, start_nxt;
  logic [NUM_COND-1:0]          held;
  logic [31:0]                  accum_r, accum_nxt;
  logic [31:0]                  resume_r, resume_nxt;
  det_state_t                   cur_r, cur_nxt;
  det_state_t                   rep_r, rep_nxt;
  logic                         fault_r, fault_nxt;
  logic                         maint_r, maint_nxt;
  logic                         ack_r, ack_nxt;
  logic                         escd_r, escd_nxt;

  logic [32:0]                  paused_sum;
  logic [32:0]                  esc_total;
  logic                         note;
  logic [2:0]                   note_ev;

  orad_cond u_cond (
    .item       (item),
    .cfg        (cfg),
    .active_cur (active_r),
    .start_cur  (start_r),
    .active_nxt (active_nxt),
    .start_nxt  (start_nxt),
    .held       (held)
  );

  always_comb begin
    latest_nxt = latest_r;
    fault_nxt  = fault_r;
    accum_nxt  = accum_r;
    resume_nxt = resume_r;
    maint_nxt  = maint_r;
    ack_nxt    = ack_r;
    escd_nxt   = escd_r;
    rep_nxt    = rep_r;
    note       = 1'b0;
    note_ev    = EV_NORMAL;
    paused_sum = {1'b0, accum_r} + {1'b0, since(item.now, resume_r)};

    case (item.kind)
      KIND_SAMPLE: begin
        latest_nxt = item.sample_value;
        fault_nxt  = item.bad_reading;
      end
      KIND_ACK: begin
        if (rep_r != ST_NORMAL) ack_nxt = 1'b1;
      end
      KIND_MAINT: begin
        if (item.maintenance_on && !maint_r) begin
          accum_nxt = paused_sum[32] ? WORD_MAX : paused_sum[31:0];
          maint_nxt = 1'b1;
        end else if (!item.maintenance_on && maint_r) begin
          maint_nxt  = 1'b0;
          resume_nxt = item.now;
        end
      end
      default: ;
    endcase

    // Transition chain: a step that changes nothing leaves later steps idle too.
    cur_nxt = cur_r;
    for (int i = 0; i < CHAIN_STEPS; i++) begin
      cur_nxt = next_state(cur_nxt, fault_nxt, held);
    end

    esc_total = {1'b0, accum_nxt} + {1'b0, since(item.now, resume_nxt)};

    if (!maint_nxt) begin
      if (cur_nxt != rep_r) begin
        rep_nxt    = cur_nxt;
        note       = 1'b1;
        note_ev    = {1'b0, state_code(cur_nxt)};
        ack_nxt    = 1'b0;
        escd_nxt   = 1'b0;
        accum_nxt  = '0;
        resume_nxt = item.now;
      end else if (rep_r != ST_NORMAL && !ack_nxt && !escd_r &&
                   cfg.escalate_after != '0 &&
                   esc_total >= {1'b0, cfg.escalate_after}) begin
        escd_nxt = 1'b1;
        note     = 1'b1;
        note_ev  = EV_OVERDUE;
      end
    end

    result.note_valid     = note;
    result.note_event     = note ? note_ev : 3'd0;
    result.note_time      = note ? item.now : 32'd0;
    result.note_value     = note ? latest_nxt : 32'sd0;
    result.detector_state = state_code(cur_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latest_r <= '0;
      active_r <= '0;
      start_r  <= '0;
      accum_r  <= '0;
      resume_r <= '0;
      cur_r    <= ST_NORMAL;
      rep_r    <= ST_NORMAL;
      fault_r  <= 1'b0;
      maint_r  <= 1'b0;
      ack_r    <= 1'b0;
      escd_r   <= 1'b0;
    end else if (step) begin
      latest_r <= latest_nxt;
      active_r <= active_nxt;
      start_r  <= start_nxt;
      accum_r  <= accum_nxt;
      resume_r <= resume_nxt;
      cur_r    <= cur_nxt;
      rep_r    <= rep_nxt;
      fault_r  <= fault_nxt;
      maint_r  <= maint_nxt;
      ack_r    <= ack_nxt;
      escd_r   <= escd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/out_of_range_alarm_detector_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// out_of_range_alarm_detector_top: out-of-range alarm detector for one point
// Usage: each input transaction is a sample, tick, acknowledge or maintenance
// switch stamped with a time, and every input transaction yields exactly one
// output transaction carrying at most one note plus the real detector state.
// Both channels use valid and stall; a transaction completes at a rising edge
// where valid is high and stall is low.
// The item is captured in the input register, the detector state and the
// result are computed from it combinationally, and the result is registered
// in the output register.
// Throughput is one transaction per cycle while the receiver does not stall;
// the input register accepts one more item while a result is waiting, so a
// stalled result holds back at most one item behind it.
// When the receiver stalls, the output register holds its result unchanged
// and the input stage asserts stall once its own item cannot move on.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata, one per cycle, while the block is idle; unknown indexes are
// ignored. A synchronous reset (rst_n low) clears the registers, the
// detector state and both pipeline stages.
// ----------------------------------------------------------------------------
module out_of_range_alarm_detector_top (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration port.
  input  logic                 cfg_we,
  input  orad_pkg::cfg_idx_t   cfg_index,
  input  logic [31:0]          cfg_wdata,
  // Input channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [31:0]          in_now,
  input  logic signed [31:0]   in_sample_value,
  input  logic                 in_sensor_fault,
  input  logic                 in_maintenance_on,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_note_valid,
  output logic [2:0]           out_note_event,
  output logic [31:0]          out_note_time,
  output logic signed [31:0]   out_note_value,
  output logic [1:0]           out_detector_state
);
  import orad_pkg::*;

  orad_cfg_t     cfg_r;
  orad_item_t    s1_item_r;
  logic          s1_valid_r, s1_valid_nxt;
  orad_result_t  res;
  orad_result_t  out_res_r;
  logic          out_valid_r, out_valid_nxt;
  logic          in_accept;
  logic          s1_move;
  logic          out_take;

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HIGH_LIMIT:     cfg_r.upper_lim      <= cfg_wdata;
        CFG_LOW_LIMIT:      cfg_r.lower_lim      <= cfg_wdata;
        CFG_DEADBAND:       cfg_r.deadband       <= cfg_wdata[30:0];
        CFG_TIME_DELAY:     cfg_r.time_delay     <= cfg_wdata;
        CFG_ESCALATE_AFTER: cfg_r.escalate_after <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves into the output register when that
  // register is empty or its transaction completes in the same cycle.
  assign out_take      = out_valid_r && !out_stall;
  assign s1_move       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !s1_move;
  assign in_accept     = in_valid && !in_stall;
  assign s1_valid_nxt  = in_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_move ? 1'b1 : (out_take ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.kind           <= in_kind;
      s1_item_r.now            <= in_now;
      s1_item_r.sample_value   <= in_sample_value;
      s1_item_r.bad_reading    <= in_sensor_fault;
      s1_item_r.maintenance_on <= in_maintenance_on;
    end
    if (s1_move) begin
      out_res_r <= res;
    end
  end

  // The detector state advances exactly when its item enters the output register.
  orad_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (s1_move),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (res)
  );

  assign out_valid          = out_valid_r;
  assign out_note_valid     = out_res_r.note_valid;
  assign out_note_event     = out_res_r.note_event;
  assign out_note_time      = out_res_r.note_time;
  assign out_note_value     = out_res_r.note_value;
  assign out_detector_state = out_res_r.detector_state;

endmodule
`default_nettype wire
